// ----- rtl/core/rau_pkg.sv -----
// shared codes and types for the rational arithmetic unit
`default_nettype none
package rau_pkg;

  // operation select
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
// rational arithmetic unit: add, subtract, multiply or divide two fractions and reduce
//
// One item at a time: in_stall_o stays high from the transfer of an item until its
// result is loaded into the output register, which then waits for the consumer
// while the next item may already be taken. Operands use the low WORD_BITS bits of
// each field as two's complement. Products come from one WORD_BITS x WORD_BITS
// multiplier, three for add and subtract and two for multiply and divide; everything
// after that runs on 2*WORD_BITS-wide subtract/shift logic: a binary GCD (one step per
// cycle), a shift-back of the GCD's common power of two, and two restoring divisions
// by the GCD with 2*WORD_BITS quotient bits each. An operand with a zero denominator
// goes straight to the final state. On a zero denominator or a result wider than
// WORD_BITS the result is 0/1 with a nonzero status.
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] left_num_i,
  input  wire logic [31:0] left_den_i,
  input  wire logic [31:0] right_num_i,
  input  wire logic [31:0] right_den_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_num_o,
  output logic [31:0]      result_den_o,
  output logic [1:0]       status_o
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int WW = 2 * WORD_BITS;
  localparam int CW = $clog2(WW);
  localparam logic [WW-1:0] LIM = WW'(1) << (W - 1);
  localparam logic [WW-1:0] ONE = WW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_GSH  = 3'd4;
  localparam logic [2:0] S_DIVN = 3'd5;
  localparam logic [2:0] S_DIVD = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          out_valid_q, out_valid_d;
  func_e         op_q, op_d;
  logic          err_q, err_d;
  logic          ln_s_q, ld_s_q, rn_s_q, rd_s_q;
  logic          ln_s_d, ld_s_d, rn_s_d, rd_s_d;
  logic [W-1:0]  ln_m_q, ld_m_q, rn_m_q, rd_m_q;
  logic [W-1:0]  ln_m_d, ld_m_d, rn_m_d, rd_m_d;
  logic [1:0]    ms_q, ms_d;
  logic [WW-1:0] p1_q, p1_d, p2_q, p2_d, p3_q, p3_d;
  logic [WW-1:0] nmag_q, nmag_d, dmag_q, dmag_d;
  logic          n_neg_q, n_neg_d, d_neg_q, d_neg_d;
  logic [WW-1:0] a_q, a_d, b_q, b_d, g_q, g_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [WW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0]   rnum_q, rnum_d, rden_q, rden_d;
  logic [1:0]    st_q, st_d;

  // operand words at the input, the low WORD_BITS bits of each field
  logic [W-1:0] in_ln, in_ld, in_rn, in_rd;
  assign in_ln = left_num_i[W-1:0];
  assign in_ld = left_den_i[W-1:0];
  assign in_rn = right_num_i[W-1:0];
  assign in_rd = right_den_i[W-1:0];

  // shared multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [WW-1:0] prod;
  always_comb begin
    mul_a = ln_m_q;
    mul_b = rd_m_q;
    case (ms_q)
      2'd0: begin
        mul_a = ln_m_q;
        mul_b = (op_q == FUNC_MUL) ? rn_m_q : rd_m_q;
      end
      2'd1: begin
        if (op_q == FUNC_MUL) begin
          mul_a = ld_m_q;
          mul_b = rd_m_q;
        end else if (op_q == FUNC_DIV) begin
          mul_a = ld_m_q;
          mul_b = rn_m_q;
        end else begin
          mul_a = rn_m_q;
          mul_b = ld_m_q;
        end
      end
      default: begin
        mul_a = ld_m_q;
        mul_b = rd_m_q;
      end
    endcase
  end
  assign prod = WW'(mul_a) * WW'(mul_b);

  // signed add of the two cross products
  logic          s1, s2;
  logic [WW:0]   sdif;
  logic [WW-1:0] sum_mag;
  logic          sum_neg;
  always_comb begin
    s1   = ln_s_q ^ rd_s_q;
    s2   = rn_s_q ^ ld_s_q ^ (op_q == FUNC_SUB);
    sdif = {1'b0, p1_q} - {1'b0, p2_q};
    if (s1 == s2) begin
      sum_mag = p1_q + p2_q;
      sum_neg = s1;
    end else if (!sdif[WW]) begin
      sum_mag = sdif[WW-1:0];
      sum_neg = s1;
    end else begin
      sum_mag = ~sdif[WW-1:0] + ONE;
      sum_neg = s2;
    end
  end

  // wide subtractors for the gcd and divider steps
  logic [WW:0]   gdif;
  logic [WW:0]   rem_sh;
  logic [WW+1:0] ddif;
  logic          take;
  assign gdif   = {1'b0, a_q} - {1'b0, b_q};
  assign rem_sh = {rem_q, quo_q[WW-1]};
  assign ddif   = {1'b0, rem_sh} - {2'b00, g_q};
  assign take   = !ddif[WW+1];

  // final sign handling and range check
  logic          unit;
  logic          fneg_n, fneg_d;
  logic [WW-1:0] fmag_d;
  logic          fit_n, fit_d;
  logic [W-1:0]  wn, wd;
  always_comb begin
    unit   = (dmag_q == ONE);
    fneg_n = unit ? ((n_neg_q ^ d_neg_q) && (nmag_q != '0)) : n_neg_q;
    fneg_d = unit ? 1'b0 : d_neg_q;
    fmag_d = unit ? ONE : dmag_q;
    fit_n  = fneg_n ? (nmag_q <= LIM) : (nmag_q < LIM);
    fit_d  = fneg_d ? (fmag_d <= LIM) : (fmag_d < LIM);
    wn     = fneg_n ? (~nmag_q[W-1:0] + W'(1)) : nmag_q[W-1:0];
    wd     = fneg_d ? (~fmag_d[W-1:0] + W'(1)) : fmag_d[W-1:0];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    op_d = op_q;   err_d = err_q;
    ln_s_d = ln_s_q; ld_s_d = ld_s_q; rn_s_d = rn_s_q; rd_s_d = rd_s_q;
    ln_m_d = ln_m_q; ld_m_d = ld_m_q; rn_m_d = rn_m_q; rd_m_d = rd_m_q;
    ms_d = ms_q;
    p1_d = p1_q; p2_d = p2_q; p3_d = p3_q;
    nmag_d = nmag_q; dmag_d = dmag_q; n_neg_d = n_neg_q; d_neg_d = d_neg_q;
    a_d = a_q; b_d = b_q; g_d = g_q; k_d = k_q;
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    rnum_d = rnum_q; rden_d = rden_q; st_d = st_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = func_e'(func_i);
          ln_s_d = in_ln[W-1];
          ld_s_d = in_ld[W-1];
          rn_s_d = in_rn[W-1];
          rd_s_d = in_rd[W-1];
          ln_m_d = in_ln[W-1] ? (~in_ln + W'(1)) : in_ln;
          ld_m_d = in_ld[W-1] ? (~in_ld + W'(1)) : in_ld;
          rn_m_d = in_rn[W-1] ? (~in_rn + W'(1)) : in_rn;
          rd_m_d = in_rd[W-1] ? (~in_rd + W'(1)) : in_rd;
          err_d  = (in_ld == '0) || (in_rd == '0);
          ms_d   = 2'd0;
          state_d = ((in_ld == '0) || (in_rd == '0)) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        case (ms_q)
          2'd0:    p1_d = prod;
          2'd1:    p2_d = prod;
          default: p3_d = prod;
        endcase
        ms_d = ms_q + 2'd1;
        if ((ms_q == 2'd2) || ((ms_q == 2'd1) &&
            ((op_q == FUNC_MUL) || (op_q == FUNC_DIV)))) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        if ((op_q == FUNC_ADD) || (op_q == FUNC_SUB)) begin
          nmag_d  = sum_mag;
          n_neg_d = sum_neg;
          dmag_d  = p3_q;
          d_neg_d = ld_s_q ^ rd_s_q;
        end else if (op_q == FUNC_MUL) begin
          nmag_d  = p1_q;
          n_neg_d = ln_s_q ^ rn_s_q;
          dmag_d  = p2_q;
          d_neg_d = ld_s_q ^ rd_s_q;
        end else begin
          nmag_d  = p1_q;
          n_neg_d = ln_s_q ^ rd_s_q;
          dmag_d  = p2_q;
          d_neg_d = ld_s_q ^ rn_s_q;
        end
        if ((op_q == FUNC_DIV) && (p2_q == '0)) begin
          err_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          a_d     = ((op_q == FUNC_ADD) || (op_q == FUNC_SUB)) ? sum_mag : p1_q;
          b_d     = ((op_q == FUNC_ADD) || (op_q == FUNC_SUB)) ? p3_q : p2_q;
          k_d     = '0;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        // binary gcd, one step per cycle
        if (a_q == '0) begin
          g_d     = b_q;
          state_d = S_GSH;
        end else if (b_q == '0) begin
          g_d     = a_q;
          state_d = S_GSH;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!gdif[WW]) begin
          a_d = gdif[WW-1:0] >> 1;
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end
      S_GSH: begin
        // restore the common power of two
        if (k_q == '0) begin
          rem_d   = '0;
          quo_d   = nmag_q;
          cnt_d   = '0;
          state_d = S_DIVN;
        end else begin
          g_d = g_q << 1;
          k_d = k_q - CW'(1);
        end
      end
      S_DIVN, S_DIVD: begin
        // restoring division by the gcd
        rem_d = take ? ddif[WW-1:0] : rem_sh[WW-1:0];
        quo_d = {quo_q[WW-2:0], take};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WW - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == S_DIVN) begin
            nmag_d  = {quo_q[WW-2:0], take};
            quo_d   = dmag_q;
            state_d = S_DIVD;
          end else begin
            dmag_d  = {quo_q[WW-2:0], take};
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          if (err_q) begin
            st_d = ST_ZERO_DEN;
          end else if (!fit_n || !fit_d) begin
            st_d = ST_OVERFLOW;
          end else begin
            st_d = ST_OK;
          end
          if (err_q || !fit_n || !fit_d) begin
            rnum_d = 32'd0;
            rden_d = 32'd1;
          end else begin
            rnum_d = 32'(signed'(wn));
            rden_d = 32'(signed'(wd));
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d;   err_q <= err_d;
    ln_s_q <= ln_s_d; ld_s_q <= ld_s_d; rn_s_q <= rn_s_d; rd_s_q <= rd_s_d;
    ln_m_q <= ln_m_d; ld_m_q <= ld_m_d; rn_m_q <= rn_m_d; rd_m_q <= rd_m_d;
    ms_q <= ms_d;
    p1_q <= p1_d; p2_q <= p2_d; p3_q <= p3_d;
    nmag_q <= nmag_d; dmag_q <= dmag_d; n_neg_q <= n_neg_d; d_neg_q <= d_neg_d;
    a_q <= a_d; b_q <= b_d; g_q <= g_d; k_q <= k_d;
    rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    rnum_q <= rnum_d; rden_q <= rden_d; st_q <= st_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign result_num_o = rnum_q;
  assign result_den_o = rden_q;
  assign status_o     = st_q;

endmodule
`default_nettype wire

// ----- rtl/core/rau_checker.sv -----
// port-level checks for the rational arithmetic unit, bound to the top level
`default_nettype none
module rau_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] result_num_o,
  input wire logic [31:0] result_den_o,
  input wire logic [1:0]  status_o
);
  import rau_pkg::*;

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_num_o) &&
    $stable(result_den_o) && $stable(status_o))
    else $error("held result changed");

  // a failed operation reports 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (result_num_o == 32'd0) &&
    (result_den_o == 32'd1))
    else $error("error result is not 0/1");

  // a good result never has a zero denominator
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> (result_den_o != 32'd0))
    else $error("zero denominator with ok status");

  // the unit is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .result_num_o (result_num_o),
  .result_den_o (result_den_o),
  .status_o     (status_o)
);
`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for the rational arithmetic unit core
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 600;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    status_e     st;
  } fraction_res_t;

  typedef struct {
    bit              neg;
    longint unsigned mag;
  } signed_mag_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [31:0] left_num_i = '0;
  logic [31:0] left_den_i = '0;
  logic [31:0] right_num_i = '0;
  logic [31:0] right_den_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_num_o;
  logic [31:0] result_den_o;
  logic [1:0]  status_o;

  fraction_res_t reduced_q[$];
  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_zero_den = 0;
  int  n_overflow = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  rational_arithmetic_unit_core u_top (.*);

  // clock
  always #6 clk_i = ~clk_i;

  // ---------------- prediction ----------------
  function automatic signed_mag_t to_smag(logic [31:0] v);
    signed_mag_t r;
    r.neg = v[31];
    r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic signed_mag_t smag_mul(signed_mag_t a, signed_mag_t b);
    signed_mag_t r;
    r.mag = a.mag * b.mag;
    r.neg = (a.neg != b.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic signed_mag_t smag_add(signed_mag_t a, signed_mag_t b);
    signed_mag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic longint unsigned mag_gcd(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit fits_word(signed_mag_t v);
    return v.neg ? (v.mag <= 64'h8000_0000) : (v.mag < 64'h8000_0000);
  endfunction

  function automatic fraction_res_t reduce_fraction(func_e op, logic [31:0] lnv,
      logic [31:0] ldv, logic [31:0] rnv, logic [31:0] rdv);
    signed_mag_t ln, ld, rn, rd, n, d, ldg, rdg, t1, t2;
    longint unsigned g, xn, xd;
    fraction_res_t r;
    ln = to_smag(lnv);
    ld = to_smag(ldv);
    rn = to_smag(rnv);
    rd = to_smag(rdv);
    r.st = ST_OK;
    if (ld.mag == 0 || rd.mag == 0) begin
      r.st = ST_ZERO_DEN;
    end else if (op == FUNC_ADD || op == FUNC_SUB) begin
      // common denominator over the lcm
      g = mag_gcd(ld.mag, rd.mag);
      rdg = rd;
      ldg = ld;
      rdg.mag = rd.mag / g;
      ldg.mag = ld.mag / g;
      d = smag_mul(ld, rdg);
      t1 = smag_mul(ln, rdg);
      t2 = smag_mul(rn, ldg);
      if (op == FUNC_SUB && t2.mag != 0) t2.neg = !t2.neg;
      n = smag_add(t1, t2);
    end else if (op == FUNC_MUL) begin
      n = smag_mul(ln, rn);
      d = smag_mul(ld, rd);
    end else begin
      n = smag_mul(ln, rd);
      d = smag_mul(ld, rn);
      if (d.mag == 0) r.st = ST_ZERO_DEN;
    end
    if (r.st == ST_OK) begin
      // integer results collapse to value/1, else divide by the gcd
      if (n.mag % d.mag == 0) begin
        n.mag = n.mag / d.mag;
        n.neg = (n.neg != d.neg) && (n.mag != 0);
        d.neg = 1'b0;
        d.mag = 1;
      end else begin
        g = mag_gcd(n.mag, d.mag);
        n.mag = n.mag / g;
        d.mag = d.mag / g;
      end
      if (!fits_word(n) || !fits_word(d)) r.st = ST_OVERFLOW;
    end
    if (r.st != ST_OK) begin
      r.num = 32'd0;
      r.den = 32'd1;
    end else begin
      xn = n.neg ? (64'd0 - n.mag) : n.mag;
      xd = d.neg ? (64'd0 - d.mag) : d.mag;
      r.num = xn[31:0];
      r.den = xd[31:0];
    end
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic send_fraction_pair(func_e op, logic [31:0] lnv, logic [31:0] ldv,
      logic [31:0] rnv, logic [31:0] rdv);
    bit taken;
    // random gap before the item
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i  = 1'b1;
    func_i      = op;
    left_num_i  = lnv;
    left_den_i  = ldv;
    right_num_i = rnv;
    right_den_i = rdv;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    reduced_q.push_back(reduce_fraction(op, lnv, ldv, rnv, rdv));
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0, 1:    return $urandom();
      2, 3, 4: return 32'($signed($urandom_range(40)) - 20);
      5:       return 32'($signed($urandom_range(2000)) - 1000);
      6: begin
        case ($urandom_range(5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          4: return 32'h8000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      7:       return 32'($signed($urandom_range(131072)) - 65536);
      8:       return 32'(1) << $urandom_range(31);
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic logic [31:0] pick_den();
    // zero denominators appear now and then
    if ($urandom_range(29) == 0) return 32'd0;
    return pick_operand();
  endfunction

  task automatic send_random_batch(int count);
    repeat (count)
      send_fraction_pair(func_e'($urandom_range(3)), pick_operand(), pick_den(),
                         pick_operand(), pick_den());
  endtask

  task automatic wait_drained();
    wait (reduced_q.size() == 0);
    @(negedge clk_i);
  endtask

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    int hold_cnt;
    if (hold_req) begin
      out_stall_i <= 1'b1;
      hold_cnt = 0;
      while (hold_cnt < HOLD_CYCLES) begin
        @(negedge clk_i);
        hold_cnt++;
      end
      hold_req = 1'b0;
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------- checking ----------------
  always @(posedge clk_i) begin
    fraction_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected result %h/%h status %0d", $time,
                 result_num_o, result_den_o, status_o);
        errors++;
      end else begin
        exp_r = reduced_q.pop_front();
        n_checked++;
        if (exp_r.st == ST_ZERO_DEN) n_zero_den++;
        if (exp_r.st == ST_OVERFLOW) n_overflow++;
        if (result_num_o !== exp_r.num) begin
          $display("%0t: numerator expected %h actual %h", $time, exp_r.num, result_num_o);
          errors++;
        end
        if (result_den_o !== exp_r.den) begin
          $display("%0t: denominator expected %h actual %h", $time, exp_r.den,
                   result_den_o);
          errors++;
        end
        if (status_o !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 reduced_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_fraction_pair(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction_pair(FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_fraction_pair(FUNC_MUL, 32'd3, 32'd4, 32'd4, 32'd3);
    send_fraction_pair(FUNC_DIV, 32'd3, 32'd4, 32'd3, 32'd4);
    send_fraction_pair(FUNC_ADD, 32'd6, 32'd3, 32'd0, 32'd5);
    send_fraction_pair(FUNC_MUL, 32'd1, 32'hffff_fffe, 32'd1, 32'd1);
    send_fraction_pair(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_fraction_pair(FUNC_SUB, 32'd1, 32'd1, 32'd1, 32'd0);
    send_fraction_pair(FUNC_DIV, 32'd1, 32'd2, 32'd0, 32'd7);
    send_fraction_pair(FUNC_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_fraction_pair(FUNC_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_fraction_pair(FUNC_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_pair(FUNC_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000);
    send_fraction_pair(FUNC_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_fraction_pair(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000);
    send_fraction_pair(FUNC_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'd1);
    send_fraction_pair(FUNC_SUB, 32'd0, 32'h8000_0000, 32'd0, 32'd1);
    send_fraction_pair(FUNC_ADD, 32'd5, 32'hffff_fffa, 32'd7, 32'd10);
    send_fraction_pair(FUNC_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                       32'hffff_ffff);
    send_fraction_pair(FUNC_DIV, 32'd12, 32'd35, 32'hffff_fff8, 32'd21);
    wait_drained();
  endtask

  task automatic test_idle_mix();
    send_idle_pct = 13;
    recv_idle_pct = 55;
    send_random_batch(450);
    send_idle_pct = 55;
    recv_idle_pct = 13;
    send_random_batch(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_batch(400);
  endtask

  task automatic test_hold_off();
    // consumer holds off while items keep coming, then a full drain pause
    recv_idle_pct = 20;
    hold_req = 1'b1;
    send_random_batch(8);
    wait_drained();
    send_random_batch(60);
    wait_drained();
    recv_idle_pct = 0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_idle_mix();
    test_hold_off();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d fraction pairs over all four operations, %0d results checked",
             n_sent, n_checked);
    $display("%0d zero-denominator and %0d overflow results, %0d errors",
             n_zero_den, n_overflow, errors);
    if (errors == 0 && reduced_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/rau_pkg.sv
rtl/core/rational_arithmetic_unit_core.sv
rtl/core/rau_checker.sv
bench/tb.sv
